/* rtl/bls_pkg.sv */
// ----------------------------------------------------------------------------
// Bilinear sampler package
// Shared constants, edge-mode and configuration-index codes.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int MAX_ROWS_DEF      = 256;
    localparam int MAX_COLUMNS_DEF   = 256;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int COORD_W   = 24;   // signed sample coordinate width
    localparam int DIM_REG_W = 9;    // image_rows / image_columns register width
    localparam int PIX_W     = 8;    // pixel width
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        EDGE_CONST  = 2'd0,
        EDGE_MIRROR = 2'd1,
        EDGE_WRAP   = 2'd2
    } t_edge_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS      = 2'd0,
        CFG_COLUMNS   = 2'd1,
        CFG_EDGE_MODE = 2'd2,
        CFG_FILL      = 2'd3
    } t_cfg_index;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

endpackage

/* rtl/bls_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/bls_axis.sv */
// ----------------------------------------------------------------------------
// Bilinear sampler coordinate unit
// Fold one signed fixed-point coordinate by the edge mode and give the two
// neighbour indices and the fraction. Modulo runs one quotient bit a stage.
// ----------------------------------------------------------------------------
module bls_axis #(
    parameter int MAX_DIM   = bls_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = bls_pkg::FRACTION_BITS_DEF,
    localparam int DW       = $clog2(MAX_DIM + 1),
    localparam int IW       = $clog2(MAX_DIM)
) (
    input  logic                               i_clk,
    input  logic signed [bls_pkg::COORD_W-1:0] i_x,
    input  logic        [DW-1:0]               i_dim,
    input  bls_pkg::t_edge_mode                i_mode,
    output logic        [IW-1:0]               o_index0,
    output logic        [IW-1:0]               o_index1,
    output logic        [FRAC_BITS-1:0]        o_frac,
    output logic                               o_outside,
    output logic                               o_next_ok
);
    import bls_pkg::*;

    localparam int QW  = COORD_W - FRAC_BITS;
    localparam int DFW = DW + FRAC_BITS;
    localparam int XW  = ((DFW > COORD_W) ? DFW : COORD_W) + 1;

    logic [COORD_W-1:0] mag;

    logic        [DW-1:0]        r_rem  [QW];
    logic        [QW-1:0]        r_q    [QW];
    logic signed [COORD_W-1:0]   r_x    [QW];
    logic        [FRAC_BITS-1:0] r_frac [QW];

    assign mag = i_x[COORD_W-1] ? (~i_x + COORD_W'(1)) : i_x;

    // restoring remainder of the integer magnitude by the dimension
    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic        [DW-1:0]        prev_rem;
        logic        [QW-1:0]        prev_q;
        logic signed [COORD_W-1:0]   prev_x;
        logic        [FRAC_BITS-1:0] prev_frac;
        logic        [DW:0]          sh;

        if (g == 0) begin : g_first
            assign prev_rem  = '0;
            assign prev_q    = mag[COORD_W-1:FRAC_BITS];
            assign prev_x    = i_x;
            assign prev_frac = mag[FRAC_BITS-1:0];
        end else begin : g_next
            assign prev_rem  = r_rem[g-1];
            assign prev_q    = r_q[g-1];
            assign prev_x    = r_x[g-1];
            assign prev_frac = r_frac[g-1];
        end

        assign sh = {prev_rem, prev_q[QW-1-g]};

        always_ff @(posedge i_clk) begin
            if (sh >= {1'b0, i_dim}) begin
                r_rem[g] <= DW'(sh - {1'b0, i_dim});
            end else begin
                r_rem[g] <= DW'(sh);
            end
            r_q[g]    <= prev_q;
            r_x[g]    <= prev_x;
            r_frac[g] <= prev_frac;
        end
    end

    logic signed [COORD_W-1:0] x;
    logic                      neg;
    logic        [DFW-1:0]     m;
    logic        [DFW-1:0]     d;
    logic        [DFW-1:0]     d_last;
    logic        [DFW-1:0]     d_minus_m;
    logic signed [XW-1:0]      x_w;
    logic signed [XW-1:0]      d_w;
    logic        [DFW-1:0]     res;
    logic        [DW-1:0]      i0;
    logic        [DW-1:0]      p;
    logic        [DW-1:0]      i1;

    assign x         = r_x[QW-1];
    assign neg       = x[COORD_W-1];
    assign m         = {r_rem[QW-1], r_frac[QW-1]};
    assign d         = {i_dim, {FRAC_BITS{1'b0}}};
    assign d_last    = {i_dim - DW'(1), {FRAC_BITS{1'b0}}};
    assign d_minus_m = d - m;
    assign x_w       = XW'(x);
    assign d_w       = signed'(XW'(d));

    always_comb begin
        case (i_mode)
            EDGE_WRAP: begin
                if (neg) begin
                    res = (m == '0) ? '0 : d_minus_m;
                end else begin
                    res = m;
                end
            end
            EDGE_MIRROR: begin
                if (neg || x_w < d_w) begin
                    res = m;
                end else if (x_w == d_w || m == '0) begin
                    res = d_last;
                end else begin
                    res = d_minus_m;
                end
            end
            default: res = x_w[DFW-1:0];
        endcase
    end

    assign i0 = res[DFW-1:FRAC_BITS];
    assign p  = i0 + DW'(1);

    always_comb begin
        case (i_mode)
            EDGE_MIRROR: i1 = (p == i_dim) ? (i_dim - DW'(1)) : p;
            EDGE_WRAP:   i1 = (p == i_dim) ? '0 : p;
            default:     i1 = p;
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_index0  <= IW'(i0);
        o_index1  <= IW'(i1);
        o_frac    <= res[FRAC_BITS-1:0];
        o_outside <= (i_mode == EDGE_CONST) && (neg || x_w >= d_w);
        o_next_ok <= (i_mode != EDGE_CONST) || (p < i_dim);
    end

endmodule

/* rtl/bilinear_sampler_edge_modes_top.sv */
// ----------------------------------------------------------------------------
// Bilinear sampler with edge modes
// Load an 8-bit image into a replicated pixel store, then return the
// bilinear blend of four neighbours for each fixed-point sample coordinate.
// ----------------------------------------------------------------------------
// Pipeline: input register, the bit-per-stage coordinate modulo, the store
//   read, the weight and product registers, then the output queue.
// Throughput: one transaction (load or sample) per cycle while s_axis_tready
//   is high; four store copies give the four neighbour reads in the same cycle.
// Reset: clears configuration to 256x256, constant mode, fill 0, and empties
//   the pipeline and output queue; the pixel store is undefined until loaded.
module bilinear_sampler_edge_modes_top #(
    parameter int MAX_ROWS      = bls_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS   = bls_pkg::MAX_COLUMNS_DEF,
    parameter int FRACTION_BITS = bls_pkg::FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [bls_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bls_pkg::DIM_REG_W-1:0]     i_cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // load_row[7:0], load_column[15:8], load_value[23:16],
    // sample_row[47:24], sample_column[71:48]
    input  logic [71:0]                       s_axis_tdata,
    // operation[0]
    input  logic [0:0]                        s_axis_tuser,
    // frame_end
    input  logic                              s_axis_tlast,
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // sample_value[7:0]
    output logic [7:0]                        m_axis_tdata,
    // frame_end_out
    output logic                              m_axis_tlast
);
    import bls_pkg::*;

    localparam int DRW  = $clog2(MAX_ROWS + 1);
    localparam int DCW  = $clog2(MAX_COLUMNS + 1);
    localparam int IRW  = $clog2(MAX_ROWS);
    localparam int ICW  = $clog2(MAX_COLUMNS);
    localparam int AW   = IRW + ICW;
    localparam int QW   = COORD_W - FRACTION_BITS;
    localparam int AXL  = QW + 1;                  // coordinate unit latency
    localparam int FAW  = $clog2(AXL + 4);
    localparam int FD   = 1 << FAW;                // output queue depth
    localparam int CRW  = FAW + 1;
    localparam int ROWS_RST = (MAX_ROWS < 256) ? MAX_ROWS : 256;
    localparam int COLS_RST = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
    localparam int WTW  = 2 * FRACTION_BITS + 2;   // blend weight width
    localparam int PW   = WTW + PIX_W;             // weighted pixel width
    localparam int SW   = PW + 2;

    typedef struct packed {
        logic                      valid;
        logic                      op;
        logic [7:0]                lr;
        logic [7:0]                lc;
        logic [PIX_W-1:0]          lv;
        logic                      fe;
    } t_item;

    // ------------------------------------------------------------------
    // Configuration registers; dimensions held already clamped
    // ------------------------------------------------------------------
    logic [DRW-1:0]   r_rows_dim;
    logic [DCW-1:0]   r_cols_dim;
    t_edge_mode       r_mode;
    logic [PIX_W-1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_dim <= DRW'(ROWS_RST);
            r_cols_dim <= DCW'(COLS_RST);
            r_mode     <= EDGE_CONST;
            r_fill     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ROWS: begin
                    if (i_cfg_data == '0) begin
                        r_rows_dim <= DRW'(1);
                    end else if (32'(i_cfg_data) > MAX_ROWS) begin
                        r_rows_dim <= DRW'(MAX_ROWS);
                    end else begin
                        r_rows_dim <= DRW'(i_cfg_data);
                    end
                end
                CFG_COLUMNS: begin
                    if (i_cfg_data == '0) begin
                        r_cols_dim <= DCW'(1);
                    end else if (32'(i_cfg_data) > MAX_COLUMNS) begin
                        r_cols_dim <= DCW'(MAX_COLUMNS);
                    end else begin
                        r_cols_dim <= DCW'(i_cfg_data);
                    end
                end
                CFG_EDGE_MODE: begin
                    // undefined code behaves as constant fill
                    case (i_cfg_data[1:0])
                        EDGE_MIRROR: r_mode <= EDGE_MIRROR;
                        EDGE_WRAP:   r_mode <= EDGE_WRAP;
                        default:     r_mode <= EDGE_CONST;
                    endcase
                end
                CFG_FILL: r_fill <= i_cfg_data[PIX_W-1:0];
                default:  r_fill <= r_fill;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register and credit: a sample takes a queue slot on entry
    // ------------------------------------------------------------------
    logic                      accept;
    logic                      pop;
    logic                      push;
    logic [CRW-1:0]            r_credit;
    t_item                     r_s0;
    logic signed [COORD_W-1:0] r_srow0;
    logic signed [COORD_W-1:0] r_scol0;

    assign s_axis_tready = (r_credit != CRW'(FD));
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
        end else begin
            r_s0.valid <= accept;
            r_s0.op    <= s_axis_tuser[0];
            r_s0.lr    <= s_axis_tdata[7:0];
            r_s0.lc    <= s_axis_tdata[15:8];
            r_s0.lv    <= s_axis_tdata[23:16];
            r_s0.fe    <= s_axis_tlast;
        end
        r_srow0 <= s_axis_tdata[47:24];
        r_scol0 <= s_axis_tdata[71:48];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + CRW'(accept && s_axis_tuser[0] == OP_SAMPLE)
                      - CRW'(pop);
        end
    end

    // ------------------------------------------------------------------
    // Coordinate fold, one unit per axis; item fields ride alongside
    // ------------------------------------------------------------------
    logic [IRW-1:0]           row0, row1;
    logic [ICW-1:0]           col0, col1;
    logic [FRACTION_BITS-1:0] t_frac, u_frac;
    logic                     row_out, col_out, row_ok, col_ok;

    bls_axis #(.MAX_DIM(MAX_ROWS), .FRAC_BITS(FRACTION_BITS)) u_row (
        .i_clk     (i_clk),
        .i_x       (r_srow0),
        .i_dim     (r_rows_dim),
        .i_mode    (r_mode),
        .o_index0  (row0),
        .o_index1  (row1),
        .o_frac    (t_frac),
        .o_outside (row_out),
        .o_next_ok (row_ok)
    );

    bls_axis #(.MAX_DIM(MAX_COLUMNS), .FRAC_BITS(FRACTION_BITS)) u_col (
        .i_clk     (i_clk),
        .i_x       (r_scol0),
        .i_dim     (r_cols_dim),
        .i_mode    (r_mode),
        .o_index0  (col0),
        .o_index1  (col1),
        .o_frac    (u_frac),
        .o_outside (col_out),
        .o_next_ok (col_ok)
    );

    t_item r_pl [AXL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AXL; k++) begin
                r_pl[k] <= '0;
            end
        end else begin
            r_pl[0] <= r_s0;
            for (int k = 1; k < AXL; k++) begin
                r_pl[k] <= r_pl[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel store: four identical copies, one per neighbour. Loads write
    // at the same stage where samples read, so store order follows the
    // transaction order.
    // ------------------------------------------------------------------
    t_item              pl;
    logic               store_we;
    logic [AW-1:0]      store_waddr;
    logic [AW-1:0]      raddr [4];
    logic [PIX_W-1:0]   rdata [4];

    assign pl          = r_pl[AXL-1];
    assign store_we    = pl.valid && (pl.op == OP_LOAD)
                      && (32'(pl.lr) < MAX_ROWS) && (32'(pl.lc) < MAX_COLUMNS);
    assign store_waddr = {IRW'(pl.lr), ICW'(pl.lc)};
    assign raddr[0]    = {row0, col0};
    assign raddr[1]    = {row1, col0};
    assign raddr[2]    = {row1, col1};
    assign raddr[3]    = {row0, col1};

    for (genvar b = 0; b < 4; b++) begin : g_copy
        bls_ram #(.WIDTH(PIX_W), .DEPTH(1 << AW)) u_store (
            .i_clk   (i_clk),
            .i_we    (store_we),
            .i_waddr (store_waddr),
            .i_wdata (pl.lv),
            .i_raddr (raddr[b]),
            .o_rdata (rdata[b])
        );
    end

    // weights form while the store is read
    logic [FRACTION_BITS:0] om_t, om_u;
    logic [WTW-1:0]         r_w [4];
    t_item                  r_s2;
    logic                   r_out2, r_rok2, r_cok2;

    assign om_t = (FRACTION_BITS+1)'(1 << FRACTION_BITS) - {1'b0, t_frac};
    assign om_u = (FRACTION_BITS+1)'(1 << FRACTION_BITS) - {1'b0, u_frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= pl;
        end
        r_w[0] <= WTW'(om_t) * WTW'(om_u);
        r_w[1] <= WTW'({1'b0, t_frac}) * WTW'(om_u);
        r_w[2] <= WTW'({1'b0, t_frac}) * WTW'({1'b0, u_frac});
        r_w[3] <= WTW'(om_t) * WTW'({1'b0, u_frac});
        r_out2 <= row_out || col_out;
        r_rok2 <= row_ok;
        r_cok2 <= col_ok;
    end

    // ------------------------------------------------------------------
    // Weighted neighbours; in constant mode a neighbour past the last row
    // or column reads the fill value
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] y [4];
    logic [PW-1:0]    r_prod [4];
    t_item            r_s3;
    logic             r_out3;

    assign y[0] = rdata[0];
    assign y[1] = r_rok2 ? rdata[1] : r_fill;
    assign y[2] = (r_rok2 && r_cok2) ? rdata[2] : r_fill;
    assign y[3] = r_cok2 ? rdata[3] : r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3 <= '0;
        end else begin
            r_s3 <= r_s2;
        end
        for (int k = 0; k < 4; k++) begin
            r_prod[k] <= PW'(r_w[k]) * PW'(y[k]);
        end
        r_out3 <= r_out2;
    end

    logic [SW-1:0]    acc;
    logic [PIX_W-1:0] value;

    assign acc   = SW'(r_prod[0]) + SW'(r_prod[1]) + SW'(r_prod[2]) + SW'(r_prod[3]);
    // constant mode outside the image returns the fill value
    assign value = r_out3 ? r_fill : acc[2*FRACTION_BITS +: PIX_W];
    assign push  = r_s3.valid && (r_s3.op == OP_SAMPLE);

    // ------------------------------------------------------------------
    // Output queue: sized to the pipeline so the credit never overflows it
    // ------------------------------------------------------------------
    logic [PIX_W:0] r_q_data [FD];
    logic [FAW-1:0] r_wp, r_rp;
    logic [CRW-1:0] r_fcnt;

    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (r_fcnt != '0);
    assign m_axis_tdata  = r_q_data[r_rp][PIX_W-1:0];
    assign m_axis_tlast  = r_q_data[r_rp][PIX_W];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_data[r_wp] <= {r_s3.fe, value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fcnt <= '0;
        end else begin
            r_wp   <= r_wp + FAW'(push);
            r_rp   <= r_rp + FAW'(pop);
            r_fcnt <= r_fcnt + CRW'(push) - CRW'(pop);
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CRW'(FD))
        else $error("credit count above queue depth");

    a_queue_in_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_credit)
        else $error("queued results exceed samples in flight");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_fcnt != CRW'(FD)))
        else $error("result pushed into a full queue");

    a_out_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_credit != '0))
        else $error("result offered with no sample in flight");

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Bilinear sampler with edge modes - testbench
// Drives load and sample transactions with random gaps and output stalls,
// predicts every blended pixel from a shadow image and shadow registers, and
// compares each output transaction with the oldest expected pixel.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bls_pkg::*;

    localparam int  SCALE     = 1 << FRACTION_BITS_DEF;
    localparam int  SETTLE    = 40;       // beyond the sample latency
    localparam int  LIMIT     = 600000;
    localparam int  NUM_PHASE = 16;

    // ------------------------------------------------------------------------
    // Shadow image, shadow registers and the queue of expected pixels.
    // ------------------------------------------------------------------------
    class blend_scoreboard;
        logic [7:0]  pixels [MAX_ROWS_DEF*MAX_COLUMNS_DEF];
        bit          written[MAX_ROWS_DEF*MAX_COLUMNS_DEF];
        int          rows_reg, cols_reg;
        logic [1:0]  mode_reg;
        int          fill_reg;
        bit [8:0]    pixel_q[$];          // {frame_end, sample_value}
        int          errors;

        function new();
            rows_reg = 256; cols_reg = 256; mode_reg = EDGE_CONST; fill_reg = 0;
            errors = 0;
        endfunction

        function void write_reg(t_cfg_index idx, int v);
            case (idx)
                CFG_ROWS:      rows_reg = v & 'h1FF;
                CFG_COLUMNS:   cols_reg = v & 'h1FF;
                CFG_EDGE_MODE: mode_reg = v & 'h3;
                CFG_FILL:      fill_reg = v & 'hFF;
            endcase
        endfunction

        function int eff_rows();
            return (rows_reg < 1) ? 1 : (rows_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows_reg;
        endfunction

        function int eff_cols();
            return (cols_reg < 1) ? 1 : (cols_reg > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF
                                                                   : cols_reg;
        endfunction

        function longint fold(longint x, longint dim, longint unit, logic [1:0] m);
            longint d;
            d = dim * unit;
            if (m == EDGE_MIRROR) begin
                if (x < 0) x = (-x) % d;
                if (x > d) x = d - (x % d);
                if (x == d) x = (dim - 1) * unit;
            end else if (m == EDGE_WRAP) begin
                if (x < 0) x = d - ((-x) % d);
                if (x == d) x = 0;
                if (x > d) x = x % d;
            end
            return x;
        endfunction

        // Read one pixel; clear ok when it was never loaded.
        function longint fetch(longint r, longint c, inout bit ok);
            int a;
            a = int'(r) * MAX_COLUMNS_DEF + int'(c);
            if (!written[a]) ok = 0;
            return pixels[a];
        endfunction

        // Blend at a raw 24-bit coordinate pair; ok tells whether only
        // loaded pixels were read.
        function bit [7:0] predict_blend(logic [23:0] row_bits, logic [23:0] col_bits,
                                         output bit ok);
            longint rows, cols, r, c, r0, c0, r1, c1, t, u, y0, y1, y2, y3, fill, acc;
            logic [1:0] m;
            ok   = 1;
            rows = eff_rows();
            cols = eff_cols();
            m    = (mode_reg == EDGE_MIRROR || mode_reg == EDGE_WRAP) ? mode_reg : EDGE_CONST;
            fill = fill_reg;
            r    = longint'($signed(row_bits));
            c    = longint'($signed(col_bits));
            if (m == EDGE_CONST) begin
                if (r < 0 || r >= rows * SCALE || c < 0 || c >= cols * SCALE)
                    return fill[7:0];
            end else begin
                r = fold(r, rows, SCALE, m);
                c = fold(c, cols, SCALE, m);
            end
            r0 = r / SCALE;
            c0 = c / SCALE;
            t  = r - r0 * SCALE;
            u  = c - c0 * SCALE;
            if (m == EDGE_CONST) begin
                r1 = r0 + 1;
                c1 = c0 + 1;
                y0 = fetch(r0, c0, ok);
                y1 = (r1 < rows) ? fetch(r1, c0, ok) : fill;
                y3 = (c1 < cols) ? fetch(r0, c1, ok) : fill;
                y2 = (r1 < rows && c1 < cols) ? fetch(r1, c1, ok) : fill;
            end else begin
                r1 = fold(r0 + 1, rows, 1, m);
                c1 = fold(c0 + 1, cols, 1, m);
                y0 = fetch(r0, c0, ok);
                y1 = fetch(r1, c0, ok);
                y2 = fetch(r1, c1, ok);
                y3 = fetch(r0, c1, ok);
            end
            acc = (SCALE - t) * (SCALE - u) * y0 + t * (SCALE - u) * y1
                + t * u * y2 + (SCALE - t) * u * y3;
            return acc[2*FRACTION_BITS_DEF +: 8];
        endfunction

        function void note_input(logic op, logic [71:0] data, logic last);
            bit ok;
            bit [7:0] v;
            int a;
            if (op == OP_LOAD) begin
                a = int'(data[7:0]) * MAX_COLUMNS_DEF + int'(data[15:8]);
                pixels[a]  = data[23:16];
                written[a] = 1;
            end else begin
                v = predict_blend(data[47:24], data[71:48], ok);
                pixel_q.push_back({last, v});
            end
        endfunction

        function void check_result(logic [7:0] v, logic last);
            bit [8:0] e;
            if (pixel_q.size() == 0) begin
                $error("unexpected result: sample_value %0d", v);
                errors++;
                return;
            end
            e = pixel_q.pop_front();
            if (v !== e[7:0]) begin
                $error("sample_value: expected %0d, actual %0d", e[7:0], v);
                errors++;
            end
            if (last !== e[8]) begin
                $error("frame_end_out: expected %0d, actual %0d", e[8], last);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [DIM_REG_W-1:0]  i_cfg_data = '0;
    logic                  s_axis_tvalid = 0;
    logic                  s_axis_tready;
    logic [71:0]           s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  s_axis_tlast = 0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 0;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;

    bilinear_sampler_edge_modes_top uut (.*);

    blend_scoreboard sb = new();
    bit  no_idle = 0;     // set for stretches that run at full rate
    int  cycles  = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("bilinear_sampler_edge_modes_top verification failed");
            $finish;
        end
    end

    // Check every output transaction against the oldest expected pixel.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // Stall the output: hold tready low for a random count before each result.
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        m_axis_tready <= 1;
        forever begin
            do @(posedge i_clk); while (!m_axis_tvalid);
            n = no_idle ? 0 : $urandom_range(0, 8);
            if (n > 0) begin
                m_axis_tready <= 0;
                repeat (n) @(posedge i_clk);
                m_axis_tready <= 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(t_cfg_index idx, int v);
        i_cfg_we    <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= v[DIM_REG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 0;
        sb.write_reg(idx, v);
    endtask

    // Send one transaction after a random gap; leave tvalid high afterwards
    // so back-to-back items need no extra edge.
    task automatic send(logic op, logic [71:0] data, logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(op, data, last);
    endtask

    task automatic load_pixel(int r, int c, int v);
        logic [71:0] d;
        d = {8'($urandom()), $urandom(), $urandom()};
        d[23:0] = {v[7:0], c[7:0], r[7:0]};
        send(OP_LOAD, d, 1'($urandom_range(0, 1)));
    endtask

    task automatic sample_at(logic [23:0] r, logic [23:0] c, logic last);
        logic [71:0] d;
        d = {8'($urandom()), $urandom(), $urandom()};
        d[71:24] = {c, r};
        send(OP_SAMPLE, d, last);
    endtask

    // Drop tvalid and hold off until every expected pixel has come back.
    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (sb.pixel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_coord(int e);
        int k;
        case ($urandom_range(0, 3))
            0: return 24'($urandom());
            1: return 24'($urandom_range(0, 3 * e * SCALE) - e * SCALE);
            2: begin
                k = $urandom_range(0, 4) - 2;
                return 24'(k * e * SCALE + $urandom_range(0, 6) - 3);
            end
            default: return 24'($urandom_range(0, ((e < 12) ? e : 12) * SCALE - 1));
        endcase
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return $urandom_range(257, 511);
            3: return 256;
            default: return $urandom_range(2, 12);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int rows_v, cols_v, mode_v, fill_v, er, ec, lr, lc, n_items, drain_at, tries;
        logic [23:0] rc, cc;
        bit ok;
        bit [7:0] dummy;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset settings (256x256, constant fill 0).
        load_pixel(0, 0, 255);
        load_pixel(0, 1, 0);
        load_pixel(1, 0, 170);
        load_pixel(1, 1, 85);
        load_pixel(255, 255, 255);
        sample_at(0, 0, 0);
        sample_at(24'h000080, 24'h000080, 0);           // half way in both axes
        sample_at(24'h00FF80, 24'h00FF80, 0);           // neighbours past the edge
        sample_at(24'hFFFFFF, 0, 0);                    // just below zero
        sample_at(24'h010000, 0, 0);                    // exactly at the dimension
        sample_at(24'h7FFFFF, 24'h7FFFFF, 1);
        sample_at(24'h800000, 24'h800000, 0);
        sample_at(24'h0000FF, 24'h0000FF, 1);
        drain();

        for (int p = 0; p < NUM_PHASE; p++) begin
            // Extremes first, then random settings.
            case (p)
                0: begin rows_v = 1;   cols_v = 1;   mode_v = EDGE_MIRROR; fill_v = 255; end
                1: begin rows_v = 256; cols_v = 256; mode_v = EDGE_WRAP;   fill_v = 511; end
                2: begin rows_v = 0;   cols_v = 511; mode_v = EDGE_CONST;  fill_v = 0;   end
                3: begin rows_v = 5;   cols_v = 3;   mode_v = 3;           fill_v = 170; end
                4: begin rows_v = 2;   cols_v = 2;   mode_v = EDGE_MIRROR; fill_v = 85;  end
                default: begin
                    rows_v = pick_dim();
                    cols_v = pick_dim();
                    mode_v = $urandom_range(0, 3);
                    fill_v = $urandom_range(0, 511);
                end
            endcase
            write_reg(CFG_ROWS, rows_v);
            write_reg(CFG_COLUMNS, cols_v);
            write_reg(CFG_EDGE_MODE, mode_v);
            write_reg(CFG_FILL, fill_v);
            no_idle = (p % 5 == 3);

            // Fill the image, or only its top-left corner when it is big.
            er = sb.eff_rows();
            ec = sb.eff_cols();
            if (er * ec > 144) begin
                if (er > 12) er = 12;
                if (ec > 12) ec = 12;
            end
            for (int r = 0; r < er; r++)
                for (int c = 0; c < ec; c++)
                    load_pixel(r, c, $urandom_range(0, 255));

            n_items  = 75;
            drain_at = $urandom_range(10, n_items - 10);
            for (int i = 0; i < n_items; i++) begin
                if (i == drain_at) drain();
                if ($urandom_range(0, 9) == 0) begin
                    // Stray load anywhere, sometimes overwriting the image.
                    lr = $urandom_range(0, 255);
                    lc = $urandom_range(0, 255);
                    load_pixel(lr, lc, $urandom_range(0, 255));
                end else begin
                    // Retry until only loaded pixels would be read.
                    tries = 0;
                    do begin
                        rc = pick_coord(sb.eff_rows());
                        cc = pick_coord(sb.eff_cols());
                        dummy = sb.predict_blend(rc, cc, ok);
                        tries++;
                    end while (!ok && tries < 40);
                    if (!ok) begin
                        rc = 0;
                        cc = 0;
                    end
                    sample_at(rc, cc, $urandom_range(0, 7) == 0);
                end
            end
            drain();
        end

        if (sb.errors == 0 && sb.pixel_q.size() == 0) begin
            $display("bilinear_sampler_edge_modes_top verification clean");
        end else begin
            $display("bilinear_sampler_edge_modes_top verification failed");
        end
        $finish;
    end

endmodule
